// ===== design/ppr_pkg.sv =====
package ppr_pkg;

	// Operation codes; codes five to seven behave as a query
	typedef enum logic [2:0] {
		OP_LOAD   = 3'd0,
		OP_QUERY  = 3'd1,
		OP_RADIUS = 3'd2,
		OP_ANGLE  = 3'd3,
		OP_ROTATE = 3'd4
	} ppr_op_t;

	// Datapath widths: coordinates carry 24 guard bits, angles are 2^-32 turn
	localparam int GUARD_BITS = 24;
	localparam int ACC_W      = 60;
	localparam int Z_W        = 34;
	localparam int PROD_W     = 60;
	localparam int MAG_W      = 33;

	localparam logic [29:0] GAIN_Q30     = 30'd652032874;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
		32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
	};

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic signed [31:0] new_radius;
		logic [15:0]        angle_in;
	} ppr_request_t;

	typedef struct packed {
		logic signed [31:0] x_out;
		logic signed [31:0] y_out;
		logic [32:0]        radius_out;
		logic [15:0]        angle_out;
		logic               at_origin;
	} ppr_result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETPT,
		ST_VINIT,
		ST_VITER,
		ST_VMUL,
		ST_VDONE,
		ST_PLAN,
		ST_RMUL,
		ST_RINIT,
		ST_RITER,
		ST_RDONE,
		ST_PUB
	} ppr_state_t;

	typedef struct packed {
		logic capture;
		logic set_point;
		logic vec_init;
		logic iter_vec;
		logic mul_vec;
		logic vec_done;
		logic plan;
		logic mul_rot;
		logic rot_init;
		logic iter_rot;
		logic rot_done;
		logic publish;
	} ppr_cmd_t;

	typedef struct packed {
		logic origin;
		logic iter_last;
	} ppr_stat_t;

endpackage

// ===== design/ppr_stream_if.sv =====
interface ppr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ppr_ctrl.sv =====
module ppr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  ppr_pkg::ppr_stat_t stat,
	input  logic [2:0]       in_op,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output ppr_pkg::ppr_cmd_t  cmd
);
	import ppr_pkg::*;

	ppr_state_t state_q, state_d;
	logic       final_q, final_d;
	logic       out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			final_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			final_q     <= final_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		final_d  = final_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					final_d     = 1'b0;
					unique case (in_op)
						OP_LOAD: state_d = ST_SETPT;
						OP_RADIUS: state_d = stat.origin ? ST_SETPT : ST_VINIT;
						OP_ANGLE, OP_ROTATE: state_d = ST_VINIT;
						default: begin
							state_d = ST_VINIT;
							final_d = 1'b1;
						end
					endcase
				end
			end
			ST_SETPT: begin
				cmd.set_point = 1'b1;
				final_d       = 1'b1;
				state_d       = ST_VINIT;
			end
			ST_VINIT: begin
				cmd.vec_init = 1'b1;
				state_d      = ST_VITER;
			end
			ST_VITER: begin
				cmd.iter_vec = 1'b1;
				if (stat.iter_last) state_d = ST_VMUL;
			end
			ST_VMUL: begin
				cmd.mul_vec = 1'b1;
				state_d     = ST_VDONE;
			end
			ST_VDONE: begin
				cmd.vec_done = 1'b1;
				state_d      = final_q ? ST_PUB : ST_PLAN;
			end
			ST_PLAN: begin
				cmd.plan = 1'b1;
				state_d  = ST_RMUL;
			end
			ST_RMUL: begin
				cmd.mul_rot = 1'b1;
				state_d     = ST_RINIT;
			end
			ST_RINIT: begin
				cmd.rot_init = 1'b1;
				state_d      = ST_RITER;
			end
			ST_RITER: begin
				cmd.iter_rot = 1'b1;
				if (stat.iter_last) state_d = ST_RDONE;
			end
			ST_RDONE: begin
				cmd.rot_done = 1'b1;
				final_d      = 1'b1;
				state_d      = ST_VINIT;
			end
			ST_PUB: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		if (cmd.publish) out_valid_d = 1'b1;
		else if (out_ready) out_valid_d = 1'b0;
		else out_valid_d = out_valid_q;
	end

	assign out_valid = out_valid_q;
endmodule

// ===== design/ppr_datapath.sv =====
module ppr_datapath #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ppr_pkg::ppr_cmd_t     cmd,
	output ppr_pkg::ppr_stat_t    stat,
	input  ppr_pkg::ppr_request_t req_data,
	output ppr_pkg::ppr_result_t  res_data
);
	import ppr_pkg::*;

	localparam int IW = $clog2(CORDIC_ITERATIONS);
	localparam logic [ACC_W-1:0]  ROUND_G   = ACC_W'(1) << (GUARD_BITS - 1);
	localparam logic [PROD_W-1:0] LO_ROUND  = PROD_W'(1) << 29;
	localparam logic [PROD_W-1:0] ROT_ROUND = PROD_W'(1) << (29 - GUARD_BITS);

	function automatic logic signed [31:0] round_sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0]            t;
		logic signed [ACC_W-GUARD_BITS-1:0] r;
		t = v + ROUND_G;
		r = t[ACC_W-1:GUARD_BITS];
		if (r[ACC_W-GUARD_BITS-1:31] == '0 || r[ACC_W-GUARD_BITS-1:31] == '1)
			return r[31:0];
		else if (r[ACC_W-GUARD_BITS-1])
			return 32'sh8000_0000;
		else
			return 32'sh7FFF_FFFF;
	endfunction

	// captured item
	logic [2:0]         op_q;
	logic signed [31:0] new_x_q, new_y_q, new_radius_q;
	logic [15:0]        angle_in_q;

	logic signed [31:0]      point_x_q, point_y_q;
	logic signed [ACC_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]   z_q;
	logic [IW-1:0]           iter_q;
	logic [PROD_W-1:0]       prod_hi_q, prod_lo_q;
	logic [MAG_W-1:0]        mag_q, rot_mag_q;
	logic [31:0]             ang_q, rot_ang_q;
	ppr_result_t             res_q;

	logic [4:0]              k;
	logic signed [Z_W-1:0]   atan_z;
	logic signed [ACC_W-1:0] dx, dy, px_w, py_w;
	logic [29:0]             mul_hi, mul_lo;
	logic [PROD_W:0]         p_sum, mag_full;
	logic [ACC_W-1:0]        rot_x_u;
	logic [31:0]             ang_q4, ang_f;
	logic                    fold, origin, r_neg;
	logic signed [32:0]      r_ext, r_abs;

	assign k      = 5'(iter_q);
	assign atan_z = Z_W'(ATAN_TURNS[k]);
	assign dx     = y_q >>> k;
	assign dy     = x_q >>> k;
	assign px_w   = {{(ACC_W - 32 - GUARD_BITS){point_x_q[31]}}, point_x_q, {GUARD_BITS{1'b0}}};
	assign py_w   = {{(ACC_W - 32 - GUARD_BITS){point_y_q[31]}}, point_y_q, {GUARD_BITS{1'b0}}};

	// gain correction split as hi*2^30 + lo, same split serves both passes
	assign mul_hi = cmd.mul_rot ? {27'd0, rot_mag_q[MAG_W-1:30]} : x_q[59:30];
	assign mul_lo = cmd.mul_rot ? rot_mag_q[29:0] : x_q[29:0];

	assign p_sum    = {1'b0, prod_hi_q} + (PROD_W + 1)'((prod_lo_q + LO_ROUND) >> 30);
	assign mag_full = (p_sum + (PROD_W + 1)'(ROUND_G)) >> GUARD_BITS;
	assign rot_x_u  = ACC_W'(prod_hi_q << GUARD_BITS)
		+ ACC_W'((prod_lo_q + ROT_ROUND) >> (30 - GUARD_BITS));

	// angles in the left half plane are folded by half a turn
	assign ang_q4 = rot_ang_q + QUARTER_TURN;
	assign fold   = ang_q4[31];
	assign ang_f  = fold ? rot_ang_q + HALF_TURN : rot_ang_q;

	assign origin = (point_x_q == '0) && (point_y_q == '0);
	assign r_neg  = new_radius_q[31];
	assign r_ext  = {new_radius_q[31], new_radius_q};
	assign r_abs  = r_neg ? -r_ext : r_ext;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q         <= req_data.op;
			new_x_q      <= req_data.new_x;
			new_y_q      <= req_data.new_y;
			new_radius_q <= req_data.new_radius;
			angle_in_q   <= req_data.angle_in;
		end
		if (cmd.mul_vec || cmd.mul_rot) begin
			prod_hi_q <= PROD_W'(mul_hi) * PROD_W'(GAIN_Q30);
			prod_lo_q <= PROD_W'(mul_lo) * PROD_W'(GAIN_Q30);
		end
		if (cmd.vec_done) begin
			mag_q <= mag_full[MAG_W-1:0];
			ang_q <= z_q[31:0];
		end
		if (cmd.plan) begin
			unique case (op_q)
				OP_RADIUS: begin
					rot_mag_q <= MAG_W'(r_abs);
					rot_ang_q <= r_neg ? ang_q + HALF_TURN : ang_q;
				end
				OP_ANGLE: begin
					rot_mag_q <= mag_q;
					rot_ang_q <= {angle_in_q, 16'd0};
				end
				default: begin
					rot_mag_q <= mag_q;
					rot_ang_q <= ang_q + {angle_in_q, 16'd0};
				end
			endcase
		end
		if (cmd.publish) begin
			res_q.x_out      <= point_x_q;
			res_q.y_out      <= point_y_q;
			res_q.radius_out <= origin ? '0 : mag_q;
			res_q.angle_out  <= origin ? '0 : 16'((ang_q + 32'h0000_8000) >> 16);
			res_q.at_origin  <= origin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q <= '0;
			point_y_q <= '0;
			x_q       <= '0;
			y_q       <= '0;
			z_q       <= '0;
			iter_q    <= '0;
		end else begin
			if (cmd.set_point) begin
				if (op_q == OP_LOAD) begin
					point_x_q <= new_x_q;
					point_y_q <= new_y_q;
				end else begin
					point_x_q <= new_radius_q;
					point_y_q <= '0;
				end
			end else if (cmd.rot_done) begin
				point_x_q <= round_sat(x_q);
				point_y_q <= round_sat(y_q);
			end

			if (cmd.vec_init) begin
				iter_q <= '0;
				if (px_w[ACC_W-1]) begin
					x_q <= -px_w;
					y_q <= -py_w;
					z_q <= Z_W'(HALF_TURN);
				end else begin
					x_q <= px_w;
					y_q <= py_w;
					z_q <= '0;
				end
			end else if (cmd.rot_init) begin
				iter_q <= '0;
				x_q    <= fold ? -signed'(rot_x_u) : signed'(rot_x_u);
				y_q    <= '0;
				z_q    <= {{(Z_W - 32){ang_f[31]}}, ang_f};
			end else if (cmd.iter_vec) begin
				iter_q <= iter_q + 1'b1;
				if (!y_q[ACC_W-1]) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_z;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_z;
				end
			end else if (cmd.iter_rot) begin
				iter_q <= iter_q + 1'b1;
				if (!z_q[Z_W-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_z;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_z;
				end
			end
		end
	end

	assign stat.origin    = origin;
	assign stat.iter_last = (iter_q == IW'(CORDIC_ITERATIONS - 1));
	assign res_data       = res_q;
endmodule

// ===== design/polar_point_register.sv =====
// Polar point register: holds one plane point (signed Q16.16) and on each
// item loads it, queries it, sets its radius, sets its angle or rotates it,
// then returns x, y, radius (unsigned Q17.16) and angle (65536ths of a turn,
// 0 at the origin). One shared CORDIC unit does one micro-rotation a cycle.
// A query runs one vectoring pass, and a load or a radius set at the origin
// first stores the point and then runs that pass; set radius, set angle and
// rotate run a vectoring pass, a rotation pass, then the vectoring pass for
// the report. One item is in work at a time and the next item is taken the
// cycle after the result enters the output register, which holds it until
// the consumer takes it.
module polar_point_register #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input logic          clk,
	input logic          arst_n,
	ppr_stream_if.sink   request,
	ppr_stream_if.source result
);
	import ppr_pkg::*;

	ppr_cmd_t  cmd;
	ppr_stat_t stat;

	// sequencer: walks the vectoring/rotation passes and owns the handshakes
	ppr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.in_op     (request.data.op),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	// point store, CORDIC unit, gain multipliers and output register
	ppr_datapath #(
		.CORDIC_ITERATIONS (CORDIC_ITERATIONS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.req_data (request.data),
		.res_data (result.data)
	);
endmodule
